// File: hdl/window_lifter_controller_core_assert.svh
// ----------------------------------------------------------------------------
// window lifter controller assertion macros
// shared concurrent check forms, clocked on clk_i; WLC_ASSERT is disabled by rst_ni
// ----------------------------------------------------------------------------
`ifndef WINDOW_LIFTER_CONTROLLER_CORE_ASSERT_SVH
`define WINDOW_LIFTER_CONTROLLER_CORE_ASSERT_SVH

// check that is switched off while reset is asserted
`define WLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that also holds across reset
`define WLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/wlc_pkg.sv
// ----------------------------------------------------------------------------
// wlc_pkg
// types and constants of the window lifter controller
// ----------------------------------------------------------------------------
`default_nettype none

package wlc_pkg;

  localparam int unsigned WIN_POS_W   = 4;
  localparam int unsigned LAMP_BAR_W  = 10;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned DEBOUNCE_W  = 8;
  localparam int unsigned HOLD_W      = 12;
  localparam int unsigned STEP_W      = 12;
  localparam int unsigned PINCH_W     = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [HOLD_W-1:0]     HOLD_RST     = 12'd500;
  localparam logic [STEP_W-1:0]     STEP_RST     = 12'd500;
  localparam logic [PINCH_W-1:0]    PINCH_RST    = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_HOLD       = 2'd1,
    CFG_STEP       = 2'd2,
    CFG_PINCH_WAIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DEBOUNCE  = 9'b000000010,
    ST_HOLD      = 9'b000000100,
    ST_MAN_UP    = 9'b000001000,
    ST_MAN_DOWN  = 9'b000010000,
    ST_AUTO_UP   = 9'b000100000,
    ST_AUTO_DOWN = 9'b001000000,
    ST_REVERSE   = 9'b010000000,
    ST_LOCKOUT   = 9'b100000000
  } ctl_state_e;

  typedef struct packed {
    logic up_pressed;
    logic down_pressed;
    logic pinch_seen;
  } wlc_req_t;

  typedef struct packed {
    logic [WIN_POS_W-1:0]  window_position;
    logic [LAMP_BAR_W-1:0] lamp_bar;
    logic                  moving_up;
    logic                  moving_down;
    logic                  pinch_lockout;
    logic                  auto_mode;
  } wlc_res_t;

endpackage

`default_nettype wire

// File: hdl/wlc_chan_if.sv
// ----------------------------------------------------------------------------
// wlc_chan_if
// valid/ready channel carrying one payload item per request
// ----------------------------------------------------------------------------
`default_nettype none

interface wlc_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: hdl/window_lifter_controller_core.sv
// ----------------------------------------------------------------------------
// window_lifter_controller_core
// power window controller with debounce, auto/manual runs and anti-pinch
// ----------------------------------------------------------------------------
// One request is one millisecond tick carrying the button and obstacle levels;
// one result per request gives position, lamp bar and run flags after the
// update. A request is taken every cycle unless the input register and skid
// stage are both full: it lands in an input register, the control state and
// the result are updated from it combinationally, and the result sits in an
// output register backed by a one-entry skid stage; a stalled output side
// only holds off requests once both output entries and the input register are
// full. Configuration writes take effect the cycle after the write enable; the
// user must make them while the block is idle; this is not enforced.
`default_nettype none

`include "window_lifter_controller_core_assert.svh"

module window_lifter_controller_core #(
  parameter int unsigned TOP_POSITION = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wlc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [wlc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wlc_chan_if.sink                            req_i,
  wlc_chan_if.source                          res_o
);

  import wlc_pkg::*;

  localparam int unsigned POS_W = $clog2(TOP_POSITION + 1);
  localparam logic [POS_W-1:0] POS_TOP = POS_W'(TOP_POSITION);

  // configuration registers
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [HOLD_W-1:0]     hold_q;
  logic [STEP_W-1:0]     step_q;
  logic [PINCH_W-1:0]    pinch_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      hold_q       <= HOLD_RST;
      step_q       <= STEP_RST;
      pinch_wait_q <= PINCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:   debounce_q   <= cfg_data_i[DEBOUNCE_W-1:0];
        CFG_HOLD:       hold_q       <= cfg_data_i[HOLD_W-1:0];
        CFG_STEP:       step_q       <= cfg_data_i[STEP_W-1:0];
        CFG_PINCH_WAIT: pinch_wait_q <= cfg_data_i[PINCH_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic     in_valid_q;
  wlc_req_t in_q;
  logic     skid_valid_q;
  logic     advance;

  assign advance     = in_valid_q && !skid_valid_q;
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  // control state
  ctl_state_e        state_q, state_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              dir_q, dir_d;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] period;
  logic              held;
  logic              at_top;
  logic              at_open;

  // one step of a run: move on the first tick of each period
  logic [POS_W-1:0]  run_pos_up, run_pos_dn;
  logic [TICK_W-1:0] run_tick;

  always_comb begin
    tick_inc   = tick_q + TICK_W'(1);
    period     = (step_q == '0) ? TICK_W'(1) : TICK_W'(step_q);
    held       = dir_q ? in_q.up_pressed : in_q.down_pressed;
    at_top     = (pos_q >= POS_TOP);
    at_open    = (pos_q == '0);
    run_pos_up = (tick_q == '0) ? pos_q + POS_W'(1) : pos_q;
    run_pos_dn = (tick_q == '0) ? pos_q - POS_W'(1) : pos_q;
    run_tick   = (tick_inc >= period) ? '0 : tick_inc;
  end

  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    pos_d   = pos_q;
    dir_d   = dir_q;
    case (state_q)
      ST_IDLE: begin
        if (in_q.down_pressed || in_q.up_pressed) begin
          dir_d   = !in_q.down_pressed;
          tick_d  = '0;
          state_d = ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        if (!held) begin
          state_d = ST_IDLE;
          tick_d  = '0;
        end else if (tick_inc >= TICK_W'(debounce_q)) begin
          state_d = ST_HOLD;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      ST_HOLD: begin
        if (!held) begin
          state_d = dir_q ? ST_AUTO_UP : ST_AUTO_DOWN;
          tick_d  = '0;
        end else if (tick_inc >= TICK_W'(hold_q)) begin
          state_d = dir_q ? ST_MAN_UP : ST_MAN_DOWN;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      ST_MAN_UP, ST_AUTO_UP: begin
        if ((state_q == ST_MAN_UP) && !in_q.up_pressed) begin
          state_d = ST_IDLE;
          tick_d  = '0;
        end else if (at_top) begin
          state_d = ST_IDLE;
          tick_d  = '0;
        end else if (in_q.pinch_seen) begin
          state_d = ST_REVERSE;
          tick_d  = '0;
        end else begin
          pos_d  = run_pos_up;
          tick_d = run_tick;
        end
      end
      ST_MAN_DOWN, ST_AUTO_DOWN: begin
        if ((state_q == ST_MAN_DOWN) && !in_q.down_pressed) begin
          state_d = ST_IDLE;
          tick_d  = '0;
        end else if (at_open) begin
          state_d = ST_IDLE;
          tick_d  = '0;
        end else begin
          pos_d  = run_pos_dn;
          tick_d = run_tick;
        end
      end
      ST_REVERSE: begin
        if (at_open) begin
          state_d = ST_LOCKOUT;
          tick_d  = '0;
        end else begin
          pos_d  = run_pos_dn;
          tick_d = run_tick;
        end
      end
      ST_LOCKOUT: begin
        if (tick_inc >= pinch_wait_q) begin
          state_d = ST_IDLE;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      pos_q   <= POS_TOP;
      dir_q   <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
      tick_q  <= tick_d;
      pos_q   <= pos_d;
      dir_q   <= dir_d;
    end
  end

  // result from the updated state
  wlc_res_t res_d;

  always_comb begin
    res_d.window_position = WIN_POS_W'(pos_d);
    for (int i = 0; i < LAMP_BAR_W; i++) begin
      res_d.lamp_bar[i] = (32'(pos_d) > 32'(i));
    end
    res_d.moving_up     = (state_d == ST_MAN_UP) || (state_d == ST_AUTO_UP);
    res_d.moving_down   = (state_d == ST_MAN_DOWN) || (state_d == ST_AUTO_DOWN) ||
                          (state_d == ST_REVERSE);
    res_d.pinch_lockout = (state_d == ST_REVERSE) || (state_d == ST_LOCKOUT);
    res_d.auto_mode     = (state_d == ST_AUTO_UP) || (state_d == ST_AUTO_DOWN) ||
                          (state_d == ST_REVERSE);
  end

  // output register with skid stage
  logic     out_valid_q;
  wlc_res_t out_q;
  wlc_res_t skid_q;
  logic     pop;

  assign pop           = out_valid_q && res_o.ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (advance) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (advance) begin
      if (out_valid_q && !pop) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  `WLC_ASSERT(a_pos_in_range, pos_q <= POS_TOP, "position beyond travel")
  `WLC_ASSERT(a_lockout_open, (state_q == ST_LOCKOUT) |-> (pos_q == '0), "lockout not open")
  `WLC_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid without output")
  `WLC_ASSERT(a_one_direction, out_valid_q |-> !(out_q.moving_up && out_q.moving_down), "both directions")
  `WLC_ASSERT(a_stall_holds_input, (in_valid_q && skid_valid_q) |=> in_valid_q, "request lost")

endmodule

`default_nettype wire

// File: tb/wlc_checker.sv
// ----------------------------------------------------------------------------
// wlc_checker
// watches the request and result channels and the register writes, predicts
// the position, lamp bar and run flags of every tick and compares them in order
// ----------------------------------------------------------------------------
module wlc_checker #(
  parameter int unsigned TOP_POS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  wlc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [wlc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                      req_valid_i,
  input  logic                      req_ready_i,
  input  wlc_pkg::wlc_req_t         req_payload_i,
  input  logic                      res_valid_i,
  input  logic                      res_ready_i,
  input  wlc_pkg::wlc_res_t         res_payload_i,
  output int unsigned               fail_count_o,
  output int unsigned               outstanding_o,
  output logic                      ctl_idle_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import wlc_pkg::*;

  // register copies
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [HOLD_W-1:0]     hold_q;
  logic [STEP_W-1:0]     step_q;
  logic [PINCH_W-1:0]    lockout_q;

  // controller state
  ctl_state_e         mode;
  logic [TICK_W-1:0]  tick;
  int unsigned        pos;
  logic               closing_press;

  wlc_res_t           tick_res_q[$];
  wlc_res_t           predicted;
  wlc_res_t           oldest;
  int unsigned        fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
  endtask

  // one tick of travel; at_limit when the run found the window at its end
  task automatic travel(input logic closing, output logic at_limit);
    logic [TICK_W-1:0] period;
    period = (step_q == '0) ? TICK_W'(1) : TICK_W'(step_q);
    at_limit = closing ? (pos >= TOP_POS) : (pos == 0);
    if (!at_limit) begin
      if (tick == '0) pos = closing ? pos + 1 : pos - 1;
      tick = tick + 1'b1;
      if (tick >= period) tick = '0;
    end
  endtask

  task automatic go_idle();
    mode = ST_IDLE;
    tick = '0;
  endtask

  task automatic lifter_tick(input wlc_req_t r, output wlc_res_t o);
    logic held;
    logic at_limit;
    held = closing_press ? r.up_pressed : r.down_pressed;
    case (mode)
      ST_IDLE: begin
        // open button wins when both are down
        if (r.down_pressed || r.up_pressed) begin
          closing_press = !r.down_pressed;
          tick = '0;
          mode = ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        if (!held) begin
          go_idle();
        end else begin
          tick = tick + 1'b1;
          if (tick >= debounce_q) begin
            mode = ST_HOLD;
            tick = '0;
          end
        end
      end
      ST_HOLD: begin
        if (!held) begin
          mode = closing_press ? ST_AUTO_UP : ST_AUTO_DOWN;
          tick = '0;
        end else begin
          tick = tick + 1'b1;
          if (tick >= hold_q) begin
            mode = closing_press ? ST_MAN_UP : ST_MAN_DOWN;
            tick = '0;
          end
        end
      end
      ST_MAN_UP, ST_AUTO_UP: begin
        // obstacle only counts below the closed limit
        if (mode == ST_MAN_UP && !r.up_pressed) begin
          go_idle();
        end else if (pos >= TOP_POS) begin
          go_idle();
        end else if (r.pinch_seen) begin
          mode = ST_REVERSE;
          tick = '0;
        end else begin
          travel(1'b1, at_limit);
        end
      end
      ST_MAN_DOWN, ST_AUTO_DOWN: begin
        if (mode == ST_MAN_DOWN && !r.down_pressed) begin
          go_idle();
        end else begin
          travel(1'b0, at_limit);
          if (at_limit) go_idle();
        end
      end
      ST_REVERSE: begin
        travel(1'b0, at_limit);
        if (at_limit) begin
          mode = ST_LOCKOUT;
          tick = '0;
        end
      end
      ST_LOCKOUT: begin
        tick = tick + 1'b1;
        if (tick >= lockout_q) go_idle();
      end
      default: go_idle();
    endcase

    o.window_position = WIN_POS_W'(pos);
    o.lamp_bar        = LAMP_BAR_W'((64'd1 << pos) - 64'd1);
    o.moving_up       = (mode == ST_MAN_UP) || (mode == ST_AUTO_UP);
    o.moving_down     = (mode == ST_MAN_DOWN) || (mode == ST_AUTO_DOWN) ||
                        (mode == ST_REVERSE);
    o.pinch_lockout   = (mode == ST_REVERSE) || (mode == ST_LOCKOUT);
    o.auto_mode       = (mode == ST_AUTO_UP) || (mode == ST_AUTO_DOWN) ||
                        (mode == ST_REVERSE);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    = DEBOUNCE_RST;
      hold_q        = HOLD_RST;
      step_q        = STEP_RST;
      lockout_q     = PINCH_RST;
      mode          = ST_IDLE;
      tick          = '0;
      pos           = TOP_POS;
      closing_press = 1'b0;
      tick_res_q.delete();
      ctl_idle_o    <= 1'b1;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE:   debounce_q = cfg_data_i[DEBOUNCE_W-1:0];
          CFG_HOLD:       hold_q     = cfg_data_i[HOLD_W-1:0];
          CFG_STEP:       step_q     = cfg_data_i[STEP_W-1:0];
          CFG_PINCH_WAIT: lockout_q  = cfg_data_i[PINCH_W-1:0];
          default: ;
        endcase
      end

      if (req_valid_i && req_ready_i) begin
        lifter_tick(req_payload_i, predicted);
        tick_res_q.push_back(predicted);
      end

      if (res_valid_i && res_ready_i) begin
        if (tick_res_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          oldest = tick_res_q.pop_front();
          check_field("window_position", 16'(res_payload_i.window_position),
                      16'(oldest.window_position));
          check_field("lamp_bar", 16'(res_payload_i.lamp_bar), 16'(oldest.lamp_bar));
          check_field("moving_up", 16'(res_payload_i.moving_up), 16'(oldest.moving_up));
          check_field("moving_down", 16'(res_payload_i.moving_down),
                      16'(oldest.moving_down));
          check_field("pinch_lockout", 16'(res_payload_i.pinch_lockout),
                      16'(oldest.pinch_lockout));
          check_field("auto_mode", 16'(res_payload_i.auto_mode), 16'(oldest.auto_mode));
        end
      end

      ctl_idle_o    <= (mode == ST_IDLE);
      outstanding_o <= tick_res_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives button and obstacle ticks into the window lifter controller under
// several register settings and idling patterns; results are checked by
// wlc_checker
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import wlc_pkg::*;

  localparam int unsigned TOP_POS = 10;

  // up down pinch: a short press/hold, a manual run, a pinch and its lockout
  localparam logic [2:0] OPENING_SEQ [26] = '{
    3'b110, 3'b000, 3'b100, 3'b100, 3'b000, 3'b000, 3'b010, 3'b010, 3'b110,
    3'b111, 3'b010, 3'b000, 3'b101, 3'b100, 3'b000, 3'b001, 3'b110, 3'b100,
    3'b010, 3'b011, 3'b111, 3'b000, 3'b101, 3'b110, 3'b010, 3'b000
  };

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned outstanding;
  logic        ctl_idle;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent;
  int unsigned deb_cur, hold_cur, step_cur, pinch_cur;

  wlc_chan_if #(.payload_t(wlc_req_t)) req_if ();
  wlc_chan_if #(.payload_t(wlc_res_t)) res_if ();

  window_lifter_controller_core #(
    .TOP_POSITION(TOP_POS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  wlc_checker #(
    .TOP_POS(TOP_POS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_payload_i (req_if.payload),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_payload_i (res_if.payload),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .ctl_idle_o    (ctl_idle)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic int unsigned cap(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  task automatic push_tick(input wlc_req_t r);
    if ($urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic set_config(input int unsigned deb, input int unsigned hold,
                            input int unsigned step, input int unsigned pinch);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[0] = CFG_DATA_W'(deb);
    vals[1] = CFG_DATA_W'(hold);
    vals[2] = CFG_DATA_W'(step);
    vals[3] = CFG_DATA_W'(pinch);
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_idx_e'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we    <= 1'b0;
    deb_cur   = deb;
    hold_cur  = hold;
    step_cur  = step;
    pinch_cur = pinch;
  endtask

  // released ticks until the controller is back in idle, then drain results
  task automatic settle();
    push_tick('0);
    while (!ctl_idle) push_tick('0);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one button press with a timed release, or a burst of noise
  task automatic random_gesture();
    int unsigned span;
    int unsigned eff_step;
    int unsigned press_len;
    int unsigned tail_len;
    int unsigned pinch_rate;
    logic        close_btn;
    logic        both;
    wlc_req_t    r;
    eff_step = (step_cur == 0) ? 1 : step_cur;
    span     = deb_cur + hold_cur;
    if ($urandom_range(0, 9) >= 8) begin
      repeat ($urandom_range(1, 6)) push_tick(wlc_req_t'(3'($urandom_range(0, 7))));
    end else begin
      close_btn = 1'($urandom_range(0, 1));
      both      = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 2))
        0:       press_len = $urandom_range(0, deb_cur + 2);
        1:       press_len = $urandom_range(deb_cur + 1, deb_cur + 1 + cap(hold_cur, 40));
        default: press_len = $urandom_range(span + 1, span + 1 + cap(4 * eff_step, 40));
      endcase
      repeat (press_len) begin
        r.up_pressed   = close_btn ? 1'b1 : (both || $urandom_range(0, 7) == 0);
        r.down_pressed = close_btn ? (both || $urandom_range(0, 7) == 0) : 1'b1;
        r.pinch_seen   = ($urandom_range(0, 7) == 0);
        push_tick(r);
      end
      // half the releases see no obstacle so that climbs can reach the top
      pinch_rate = $urandom_range(0, 1) ? 4 : 0;
      tail_len   = $urandom_range(0, cap(12 * eff_step + pinch_cur + 4, 60));
      repeat (tail_len) begin
        r.up_pressed   = ($urandom_range(0, 15) == 0);
        r.down_pressed = ($urandom_range(0, 15) == 0);
        r.pinch_seen   = (pinch_rate != 0) && ($urandom_range(1, pinch_rate) == 1);
        push_tick(r);
      end
    end
  endtask

  task automatic run_phase(input int unsigned deb, input int unsigned hold,
                           input int unsigned step, input int unsigned pinch,
                           input int unsigned gap, input int unsigned stall,
                           input int unsigned n);
    set_config(deb, hold, step, pinch);
    gap_pct    = gap;
    stall_pct  = stall;
    items_sent = 0;
    while (items_sent < n) random_gesture();
    settle();
  endtask

  initial begin
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_DEBOUNCE;
    cfg_data       <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(0, 1, 1, 1);
    foreach (OPENING_SEQ[i]) push_tick(wlc_req_t'(OPENING_SEQ[i]));
    settle();

    run_phase(1, 3, 1, 4, 0, 0, 130);
    run_phase(0, 0, 0, 0, 61, 0, 130);
    run_phase(2, 5, 2, 6, 0, 61, 130);
    run_phase(255, 0, 1, 3, 0, 0, 150);
    // longest hold with short travel and lockout so settling stays brief
    run_phase(0, 4095, 5, 50, 0, 0, 60);
    run_phase(3, 7, 3, 10, 23, 23, 130);
    run_phase(1, 2, 1, 1, 61, 0, 130);
    run_phase(0, 1, 2, 0, 0, 61, 130);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
